// ===== hw/rtl/rotary_encoder_button_events_top_macros.svh =====
// ----------------------------------------------------------------------------
// rotary encoder button events - assertion macros
// shared concurrent assertion forms, clocked on clk and held off in reset
// ----------------------------------------------------------------------------
`ifndef ROTARY_ENCODER_BUTTON_EVENTS_TOP_MACROS_SVH
`define ROTARY_ENCODER_BUTTON_EVENTS_TOP_MACROS_SVH

// condition and consequence in the same cycle
`define REB_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// consequence in the cycle after the condition
`define REB_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== hw/rtl/reb_pkg.sv =====
// ----------------------------------------------------------------------------
// reb_pkg
// types, codes, tables and helpers shared by the encoder/button event block
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package reb_pkg;

  // tick stamp width
  localparam int TICK_BITS = 32;
  typedef logic [TICK_BITS-1:0] tick_t;

  // command queue geometry
  localparam int Q_DEPTH = 4;
  localparam int Q_PTR_W = $clog2(Q_DEPTH);
  localparam int Q_CNT_W = $clog2(Q_DEPTH + 1);

  // events per poll: three slots for each of three sources
  localparam int SLOTS = 9;
  localparam int SLOT_W = $clog2(SLOTS);

  // configuration register indexes
  localparam logic [1:0] CFG_LONG_TICKS   = 2'd0;
  localparam logic [1:0] CFG_REPEAT_TICKS = 2'd1;
  localparam logic [1:0] CFG_DEBOUNCE     = 2'd2;
  localparam logic [1:0] CFG_STEPS        = 2'd3;

  // configuration reset values
  localparam logic [31:0] LONG_TICKS_RST   = 32'd500;
  localparam logic [31:0] REPEAT_TICKS_RST = 32'd200;
  localparam logic [3:0]  DEBOUNCE_RST     = 4'd2;
  localparam logic [3:0]  STEPS_RST        = 4'd2;

  typedef enum logic [2:0] {
    KEY_UP    = 3'd0,
    KEY_DOWN  = 3'd1,
    KEY_LEFT  = 3'd2,
    KEY_RIGHT = 3'd3,
    KEY_OK    = 3'd4,
    KEY_BACK  = 3'd5
  } key_t;

  typedef enum logic [2:0] {
    KIND_PRESS   = 3'd0,
    KIND_RELEASE = 3'd1,
    KIND_SHORT   = 3'd2,
    KIND_LONG    = 3'd3,
    KIND_REPEAT  = 3'd4
  } kind_t;

  // what one source produced for a poll
  typedef enum logic [2:0] {
    GRP_NONE,
    GRP_PRESS_LONG,
    GRP_RELEASE,
    GRP_REPEAT,
    GRP_TRIPLE
  } grp_code_t;

  // quarter step per {old ab, new ab}: +1, -1 or 0
  typedef logic signed [1:0] qstep_t;
  localparam qstep_t QUARTER_STEP [16] = '{
    2'b00, 2'b11, 2'b01, 2'b00,
    2'b01, 2'b00, 2'b00, 2'b11,
    2'b11, 2'b00, 2'b00, 2'b01,
    2'b00, 2'b01, 2'b11, 2'b00
  };

  typedef struct packed {
    logic  phase_a;
    logic  phase_b;
    logic  enc_button_level;
    logic  side_key_level;
    tick_t now_tick;
  } in_item_t;

  typedef struct packed {
    logic [2:0]  event_key;
    logic [2:0]  event_kind;
    logic [31:0] event_seq;
    logic        last_of_poll;
  } out_item_t;

  // one source's share of a poll
  typedef struct packed {
    grp_code_t   code;
    key_t        key;
    logic [31:0] seq;
  } grp_t;

  // command passed from front to back
  typedef struct packed {
    grp_t side;
    grp_t btn;
    grp_t enc;
  } desc_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_stat_t;

  typedef struct packed {
    logic       raw;
    logic [3:0] polls;
    logic       pass;
  } deb_t;

  // debounce one button level
  function automatic deb_t deb_step(input logic raw_st, input logic [3:0] polls,
                                    input logic raw, input logic [3:0] dc);
    deb_t r;
    r.raw   = raw;
    r.polls = polls;
    if (raw == raw_st) begin
      if (polls < dc) r.polls = polls + 4'd1;
    end else begin
      r.polls = 4'd1;
    end
    r.pass = (r.polls >= dc);
    return r;
  endfunction

  // slots used by a group
  function automatic logic [2:0] grp_mask(input grp_code_t code);
    logic [2:0] m;
    unique case (code) inside
      GRP_PRESS_LONG:          m = 3'b011;
      GRP_RELEASE, GRP_REPEAT: m = 3'b001;
      GRP_TRIPLE:              m = 3'b111;
      default:                 m = 3'b000;
    endcase
    return m;
  endfunction

  // event kind of one slot within a group
  function automatic kind_t grp_kind(input grp_code_t code, input logic [1:0] sub);
    kind_t k;
    unique case (sub)
      2'd0: begin
        if (code == GRP_RELEASE) k = KIND_RELEASE;
        else if (code == GRP_REPEAT) k = KIND_REPEAT;
        else k = KIND_PRESS;
      end
      2'd1: k = (code == GRP_PRESS_LONG) ? KIND_LONG : KIND_SHORT;
      default: k = KIND_RELEASE;
    endcase
    return k;
  endfunction

endpackage

// ===== hw/rtl/reb_front.sv =====
// ----------------------------------------------------------------------------
// reb_front
// accepts polls, decodes the encoder and debounces both buttons, and queues
// at most one command per poll, describing the events to send
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module reb_front (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              cfg_we,
  input  logic [1:0]        cfg_index,
  input  logic [31:0]       cfg_wdata,
  input  logic              in_valid,
  input  reb_pkg::in_item_t in_data,
  output logic              in_ready,
  input  reb_pkg::q_stat_t  q_stat,
  output logic              push,
  output reb_pkg::desc_t    push_data
);

  // configuration
  logic [31:0] long_ticks_r, repeat_ticks_r;
  logic [3:0]  db_count_r, spd_r;

  // decoder and button state
  logic               primed_r, primed_nxt;
  logic [1:0]         ab_last_r, ab_last_nxt;
  logic signed [4:0]  accum_r, accum_nxt;
  logic [31:0]        seq_r, seq_nxt;
  logic               enc_raw_r, enc_raw_nxt, enc_stable_r, enc_stable_nxt;
  logic [3:0]         enc_polls_r, enc_polls_nxt;
  reb_pkg::tick_t     enc_press_time_r, enc_press_time_nxt;
  logic               enc_long_sent_r, enc_long_sent_nxt;
  logic               enc_rotated_r, enc_rotated_nxt;
  logic               key_raw_r, key_raw_nxt, key_stable_r, key_stable_nxt;
  logic [3:0]         key_polls_r, key_polls_nxt;
  reb_pkg::tick_t     key_press_time_r, key_press_time_nxt;
  logic               key_long_sent_r, key_long_sent_nxt;
  reb_pkg::tick_t     key_repeat_time_r, key_repeat_time_nxt;

  logic accept;

  assign in_ready = !q_stat.full;
  assign accept   = in_valid && in_ready;

  // configuration writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      long_ticks_r   <= reb_pkg::LONG_TICKS_RST;
      repeat_ticks_r <= reb_pkg::REPEAT_TICKS_RST;
      db_count_r     <= reb_pkg::DEBOUNCE_RST;
      spd_r          <= reb_pkg::STEPS_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        reb_pkg::CFG_LONG_TICKS:   long_ticks_r   <= cfg_wdata;
        reb_pkg::CFG_REPEAT_TICKS: repeat_ticks_r <= cfg_wdata;
        reb_pkg::CFG_DEBOUNCE:     db_count_r     <= cfg_wdata[3:0];
        reb_pkg::CFG_STEPS:        spd_r          <= cfg_wdata[3:0];
        default: ;
      endcase
    end
  end

  // per-poll classification
  always_comb begin
    logic [1:0]         ab_in;
    logic               enc_pressed, key_pressed;
    reb_pkg::qstep_t    d;
    logic signed [5:0]  acc, spd_s;
    logic               modified;
    reb_pkg::deb_t      deb;
    reb_pkg::tick_t     now;

    primed_nxt          = primed_r;
    ab_last_nxt         = ab_last_r;
    accum_nxt           = accum_r;
    seq_nxt             = seq_r;
    enc_raw_nxt         = enc_raw_r;
    enc_stable_nxt      = enc_stable_r;
    enc_polls_nxt       = enc_polls_r;
    enc_press_time_nxt  = enc_press_time_r;
    enc_long_sent_nxt   = enc_long_sent_r;
    enc_rotated_nxt     = enc_rotated_r;
    key_raw_nxt         = key_raw_r;
    key_stable_nxt      = key_stable_r;
    key_polls_nxt       = key_polls_r;
    key_press_time_nxt  = key_press_time_r;
    key_long_sent_nxt   = key_long_sent_r;
    key_repeat_time_nxt = key_repeat_time_r;

    push_data          = '0;
    push_data.enc.code  = reb_pkg::GRP_NONE;
    push_data.btn.code  = reb_pkg::GRP_NONE;
    push_data.side.code = reb_pkg::GRP_NONE;

    ab_in       = {in_data.phase_a, in_data.phase_b};
    enc_pressed = !in_data.enc_button_level;
    key_pressed = !in_data.side_key_level;
    now         = in_data.now_tick;
    d           = reb_pkg::QUARTER_STEP[{ab_last_r, ab_in}];
    spd_s       = $signed({2'b00, spd_r});
    acc         = 6'(accum_r) + 6'(d);
    modified    = enc_stable_r && !enc_long_sent_r;
    deb         = '0;

    if (accept && !primed_r) begin
      // first poll only captures levels
      primed_nxt     = 1'b1;
      ab_last_nxt    = ab_in;
      accum_nxt      = '0;
      enc_raw_nxt    = enc_pressed;
      enc_stable_nxt = enc_pressed;
      key_raw_nxt    = key_pressed;
      key_stable_nxt = key_pressed;
      enc_polls_nxt  = db_count_r;
      key_polls_nxt  = db_count_r;
    end else if (accept) begin
      // encoder quarter steps and detents
      if (ab_in != ab_last_r) begin
        ab_last_nxt = ab_in;
        if (d != 2'sd0) begin
          if (acc >= spd_s) begin
            acc = '0;
            seq_nxt = seq_nxt + 32'd1;
            push_data.enc.code = reb_pkg::GRP_TRIPLE;
            push_data.enc.key  = modified ? reb_pkg::KEY_RIGHT : reb_pkg::KEY_DOWN;
            push_data.enc.seq  = seq_nxt;
            if (modified) enc_rotated_nxt = 1'b1;
          end else if (acc <= -spd_s) begin
            acc = '0;
            seq_nxt = seq_nxt + 32'd1;
            push_data.enc.code = reb_pkg::GRP_TRIPLE;
            push_data.enc.key  = modified ? reb_pkg::KEY_LEFT : reb_pkg::KEY_UP;
            push_data.enc.seq  = seq_nxt;
            if (modified) enc_rotated_nxt = 1'b1;
          end
          accum_nxt = acc[4:0];
        end
      end

      // encoder button
      deb = reb_pkg::deb_step(enc_raw_r, enc_polls_r, enc_pressed, db_count_r);
      enc_raw_nxt   = deb.raw;
      enc_polls_nxt = deb.polls;
      push_data.btn.key = reb_pkg::KEY_OK;
      if (deb.pass) begin
        if (enc_stable_r == deb.raw) begin
          if (enc_stable_r && !enc_long_sent_r &&
              (now - enc_press_time_r) >= long_ticks_r) begin
            enc_long_sent_nxt = 1'b1;
            seq_nxt = seq_nxt + 32'd1;
            push_data.btn.code = reb_pkg::GRP_PRESS_LONG;
            push_data.btn.seq  = seq_nxt;
          end
        end else begin
          enc_stable_nxt = deb.raw;
          if (deb.raw) begin
            enc_press_time_nxt = now;
            enc_rotated_nxt    = 1'b0;
            enc_long_sent_nxt  = 1'b0;
          end else begin
            if (enc_long_sent_r) begin
              seq_nxt = seq_nxt + 32'd1;
              push_data.btn.code = reb_pkg::GRP_RELEASE;
              push_data.btn.seq  = seq_nxt;
            end else if (!enc_rotated_nxt) begin
              seq_nxt = seq_nxt + 32'd1;
              push_data.btn.code = reb_pkg::GRP_TRIPLE;
              push_data.btn.seq  = seq_nxt;
            end
            enc_rotated_nxt = 1'b0;
          end
        end
      end

      // side key
      deb = reb_pkg::deb_step(key_raw_r, key_polls_r, key_pressed, db_count_r);
      key_raw_nxt   = deb.raw;
      key_polls_nxt = deb.polls;
      push_data.side.key = reb_pkg::KEY_BACK;
      if (deb.pass) begin
        if (key_stable_r == deb.raw) begin
          if (key_stable_r) begin
            if (!key_long_sent_r && (now - key_press_time_r) >= long_ticks_r) begin
              key_long_sent_nxt   = 1'b1;
              key_repeat_time_nxt = now;
              seq_nxt = seq_nxt + 32'd1;
              push_data.side.code = reb_pkg::GRP_PRESS_LONG;
              push_data.side.seq  = seq_nxt;
            end else if (key_long_sent_r &&
                         (now - key_repeat_time_r) >= repeat_ticks_r) begin
              key_repeat_time_nxt = now;
              push_data.side.code = reb_pkg::GRP_REPEAT;
              push_data.side.seq  = seq_nxt;
            end
          end
        end else begin
          key_stable_nxt = deb.raw;
          if (deb.raw) begin
            key_press_time_nxt = now;
            key_long_sent_nxt  = 1'b0;
          end else if (!key_long_sent_r) begin
            seq_nxt = seq_nxt + 32'd1;
            push_data.side.code = reb_pkg::GRP_TRIPLE;
            push_data.side.seq  = seq_nxt;
          end else begin
            push_data.side.code = reb_pkg::GRP_RELEASE;
            push_data.side.seq  = seq_nxt;
          end
        end
      end
    end

    push = accept && ((push_data.enc.code != reb_pkg::GRP_NONE) ||
                      (push_data.btn.code != reb_pkg::GRP_NONE) ||
                      (push_data.side.code != reb_pkg::GRP_NONE));
  end

  // state registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      primed_r          <= 1'b0;
      ab_last_r         <= '0;
      accum_r           <= '0;
      seq_r             <= '0;
      enc_raw_r         <= 1'b0;
      enc_stable_r      <= 1'b0;
      enc_polls_r       <= reb_pkg::DEBOUNCE_RST;
      enc_press_time_r  <= '0;
      enc_long_sent_r   <= 1'b0;
      enc_rotated_r     <= 1'b0;
      key_raw_r         <= 1'b0;
      key_stable_r      <= 1'b0;
      key_polls_r       <= reb_pkg::DEBOUNCE_RST;
      key_press_time_r  <= '0;
      key_long_sent_r   <= 1'b0;
      key_repeat_time_r <= '0;
    end else begin
      primed_r          <= primed_nxt;
      ab_last_r         <= ab_last_nxt;
      accum_r           <= accum_nxt;
      seq_r             <= seq_nxt;
      enc_raw_r         <= enc_raw_nxt;
      enc_stable_r      <= enc_stable_nxt;
      enc_polls_r       <= enc_polls_nxt;
      enc_press_time_r  <= enc_press_time_nxt;
      enc_long_sent_r   <= enc_long_sent_nxt;
      enc_rotated_r     <= enc_rotated_nxt;
      key_raw_r         <= key_raw_nxt;
      key_stable_r      <= key_stable_nxt;
      key_polls_r       <= key_polls_nxt;
      key_press_time_r  <= key_press_time_nxt;
      key_long_sent_r   <= key_long_sent_nxt;
      key_repeat_time_r <= key_repeat_time_nxt;
    end
  end

endmodule

// ===== hw/rtl/reb_queue.sv =====
// ----------------------------------------------------------------------------
// reb_queue
// short command queue between front and back
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module reb_queue (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  reb_pkg::desc_t   push_data,
  input  logic             pop,
  output reb_pkg::desc_t   pop_data,
  output reb_pkg::q_stat_t stat
);

  reb_pkg::desc_t                   entry_r [reb_pkg::Q_DEPTH];
  logic [reb_pkg::Q_PTR_W-1:0]      wr_ptr_r, wr_ptr_nxt, rd_ptr_r, rd_ptr_nxt;
  logic [reb_pkg::Q_CNT_W-1:0]      count_r, count_nxt;

  assign stat.full  = (count_r == reb_pkg::Q_CNT_W'(reb_pkg::Q_DEPTH));
  assign stat.empty = (count_r == '0);
  assign pop_data   = entry_r[rd_ptr_r];

  // pointer and fill count update
  always_comb begin
    wr_ptr_nxt = push ? wr_ptr_r + 1'b1 : wr_ptr_r;
    rd_ptr_nxt = pop ? rd_ptr_r + 1'b1 : rd_ptr_r;
    count_nxt  = count_r;
    if (push && !pop) count_nxt = count_r + 1'b1;
    else if (pop && !push) count_nxt = count_r - 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  // storage
  always_ff @(posedge clk) begin
    if (push) entry_r[wr_ptr_r] <= push_data;
  end

endmodule

// ===== hw/rtl/reb_back.sv =====
// ----------------------------------------------------------------------------
// reb_back
// expands one command into its events, one event per cycle unless the
// receiver stalls, through an output register
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module reb_back (
  input  logic               clk,
  input  logic               rst_n,
  input  reb_pkg::q_stat_t   q_stat,
  input  reb_pkg::desc_t     q_head,
  output logic               q_pop,
  output logic               out_valid,
  input  logic               out_ready,
  output reb_pkg::out_item_t out_data
);

  reb_pkg::desc_t              desc_r, desc_nxt;
  logic [reb_pkg::SLOTS-1:0]   mask_r, mask_nxt;
  logic                        out_valid_r, out_valid_nxt;
  reb_pkg::out_item_t          out_data_r, out_data_nxt;

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // pick lowest pending slot, emit it, refill from the queue
  always_comb begin
    logic [reb_pkg::SLOTS-1:0]  one_hot, rest;
    logic [reb_pkg::SLOT_W-1:0] slot;
    logic                       can_emit, emit;
    reb_pkg::grp_t              grp;
    logic [1:0]                 sub;

    one_hot  = mask_r & (~mask_r + 1'b1);
    rest     = mask_r & ~one_hot;
    slot     = '0;
    for (int i = reb_pkg::SLOTS - 1; i >= 0; i--) begin
      if (mask_r[i]) slot = reb_pkg::SLOT_W'(i);
    end

    case (slot) inside
      4'd0, 4'd1, 4'd2: begin
        grp = desc_r.enc;
        sub = 2'(slot);
      end
      4'd3, 4'd4, 4'd5: begin
        grp = desc_r.btn;
        sub = 2'(slot - 4'd3);
      end
      default: begin
        grp = desc_r.side;
        sub = 2'(slot - 4'd6);
      end
    endcase

    can_emit = !out_valid_r || out_ready;
    emit     = can_emit && (mask_r != '0);
    q_pop    = !q_stat.empty && ((mask_r == '0) || (emit && (rest == '0)));

    desc_nxt = desc_r;
    mask_nxt = mask_r;
    if (q_pop) begin
      desc_nxt = q_head;
      mask_nxt = {reb_pkg::grp_mask(q_head.side.code),
                  reb_pkg::grp_mask(q_head.btn.code),
                  reb_pkg::grp_mask(q_head.enc.code)};
    end else if (emit) begin
      mask_nxt = rest;
    end

    out_valid_nxt = out_valid_r;
    out_data_nxt  = out_data_r;
    if (emit) begin
      out_valid_nxt           = 1'b1;
      out_data_nxt.event_key  = grp.key;
      out_data_nxt.event_kind = reb_pkg::grp_kind(grp.code, sub);
      out_data_nxt.event_seq  = grp.seq;
      out_data_nxt.last_of_poll = (rest == '0);
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mask_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      mask_r      <= mask_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    desc_r     <= desc_nxt;
    out_data_r <= out_data_nxt;
  end

endmodule

// ===== hw/rtl/rotary_encoder_button_events_top.sv =====
// ----------------------------------------------------------------------------
// rotary_encoder_button_events_top
// quadrature encoder decoder with two debounced buttons, producing key events
// ----------------------------------------------------------------------------
// A poll is taken whenever the four-entry command queue has room; the front
// decodes it at once and queues one command if it yields events. The back
// sends those events one per cycle from its output register unless the
// receiver stalls. A poll yields at most eight events (a detent triple, an
// ok press and long, and a back triple), and the sustained poll rate is set
// by the event expander in the back.
// The first poll after reset only captures the levels and yields nothing.
// No clearing pass is needed after reset.
`timescale 1ns / 1ps

`include "rotary_encoder_button_events_top_macros.svh"

module rotary_encoder_button_events_top (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               cfg_we,
  input  logic [1:0]         cfg_index,
  input  logic [31:0]        cfg_wdata,
  input  logic               in_valid,
  output logic               in_ready,
  input  reb_pkg::in_item_t  in_data,
  output logic               out_valid,
  input  logic               out_ready,
  output reb_pkg::out_item_t out_data
);

  reb_pkg::q_stat_t q_stat;
  logic             push, pop;
  reb_pkg::desc_t   push_data, q_head;

  // classification
  reb_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .in_valid  (in_valid),
    .in_data   (in_data),
    .in_ready  (in_ready),
    .q_stat    (q_stat),
    .push      (push),
    .push_data (push_data)
  );

  // command queue
  reb_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_data (push_data),
    .pop       (pop),
    .pop_data  (q_head),
    .stat      (q_stat)
  );

  // event expansion
  reb_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_stat    (q_stat),
    .q_head    (q_head),
    .q_pop     (pop),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  // checks
  `REB_ASSERT_NEXT(a_poll_continues, out_valid && out_ready && !out_data.last_of_poll, out_valid, "events of a poll not sent back to back")
  `REB_ASSERT_NOW(a_repeat_is_back, out_valid && (out_data.event_kind == reb_pkg::KIND_REPEAT), out_data.event_key == reb_pkg::KEY_BACK, "repeat event on a key other than back")
  `REB_ASSERT_NOW(a_long_is_button, out_valid && (out_data.event_kind == reb_pkg::KIND_LONG), (out_data.event_key == reb_pkg::KEY_OK) || (out_data.event_key == reb_pkg::KEY_BACK), "long event on a rotation key")

endmodule

// ===== sim/rotary_encoder_button_events_top_tb.sv =====
// ----------------------------------------------------------------------------
// rotary_encoder_button_events_top_tb
// Drives poll requests into the encoder/button event block and checks every
// event it returns against a cycle-free model of the decoder kept in the
// bench. Directed gestures come first: detents, ok short and long, back short,
// long and repeat, all-zero settings and a long receiver hold-off. Random
// gesture streams follow under several register settings, with random sender
// gaps and receiver stalls.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module rotary_encoder_button_events_top_tb;

  localparam bit PRESSED  = 1'b0;
  localparam bit RELEASED = 1'b1;
  localparam int HOLD_CYCLES  = 120;
  localparam int SETTLE_CYCLES = 16;
  localparam int WATCHDOG_NS  = 3_000_000;
  localparam int MAX_EVENTS   = 9;

  typedef enum int {PACE_FLOW, PACE_STALL, PACE_MIXED} pace_t;

  logic               clk;
  logic               rst_n;
  logic               cfg_we;
  logic [1:0]         cfg_index;
  logic [31:0]        cfg_wdata;
  logic               in_valid;
  logic               in_ready;
  reb_pkg::in_item_t  in_data;
  logic               out_valid;
  logic               out_ready;
  reb_pkg::out_item_t out_data;

  // decoder model: settings and state
  logic [31:0] cfg_long_ticks, cfg_repeat_ticks;
  logic [3:0]  cfg_debounce, cfg_steps;
  bit          primed_q;
  logic [1:0]  ab_prev;
  int          step_sum;
  logic [31:0] seq_no;
  bit          enc_raw_q, enc_held, enc_long_done, enc_turned;
  logic [3:0]  enc_cnt;
  logic [31:0] enc_t0;
  bit          key_raw_q, key_held, key_long_done;
  logic [3:0]  key_cnt;
  logic [31:0] key_t0, key_rep_t;

  reb_pkg::out_item_t poll_events[$];
  reb_pkg::out_item_t pending_events[$];
  int                 mismatch_count;

  // sender pacing and receiver hold-off request
  int          burst_left;
  bit          gaps_enabled;
  bit          hold_request;

  // random gesture generator state
  int          gen_pos, gen_dir, gen_enc_left, gen_key_left;
  bit          gen_enc_lvl, gen_key_lvl;
  logic [31:0] gen_tick;

  rotary_encoder_button_events_top DUT (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #(WATCHDOG_NS);
    $display("[FAIL] regression broken");
    $finish;
  end

  // ---------------------------------------------------------------- model --

  task automatic flag_error(input string what, input logic [63:0] got,
                            input logic [63:0] want);
    mismatch_count++;
    $display("%0t ns: %s got %0h want %0h", $time, what, got, want);
  endtask

  task automatic add_event(input reb_pkg::key_t k, input reb_pkg::kind_t kd,
                           input logic [31:0] s);
    reb_pkg::out_item_t ev;
    ev.event_key    = k;
    ev.event_kind   = kd;
    ev.event_seq    = s;
    ev.last_of_poll = 1'b0;
    if (poll_events.size() < MAX_EVENTS) poll_events.push_back(ev);
  endtask

  task automatic add_triple(input reb_pkg::key_t k, input logic [31:0] s);
    add_event(k, reb_pkg::KIND_PRESS, s);
    add_event(k, reb_pkg::KIND_SHORT, s);
    add_event(k, reb_pkg::KIND_RELEASE, s);
  endtask

  // debounce: true once the level has been seen cfg_debounce times in a row
  task automatic settle(inout bit raw_st, inout logic [3:0] cnt, input bit lvl,
                        output bit stable);
    if (lvl == raw_st) begin
      if (cnt < cfg_debounce) cnt = cnt + 4'd1;
    end else begin
      raw_st = lvl;
      cnt    = 4'd1;
    end
    stable = (cnt >= cfg_debounce);
  endtask

  // expected events of one accepted poll, appended to pending_events
  task automatic decode_poll(input reb_pkg::in_item_t it);
    logic [1:0]         ab;
    logic [31:0]        now, held_for, since_rep;
    bit                 enc_p, key_p, ok, modified;
    int                 d, acc;
    reb_pkg::out_item_t ev;
    ab    = {it.phase_a, it.phase_b};
    now   = it.now_tick;
    enc_p = !it.enc_button_level;
    key_p = !it.side_key_level;
    poll_events.delete();
    if (!primed_q) begin
      // first poll only captures levels
      primed_q  = 1'b1;
      ab_prev   = ab;
      step_sum  = 0;
      enc_raw_q = enc_p;
      enc_held  = enc_p;
      key_raw_q = key_p;
      key_held  = key_p;
      enc_cnt   = cfg_debounce;
      key_cnt   = cfg_debounce;
    end else begin
      // quadrature decode and detent accumulation
      if (ab != ab_prev) begin
        case ({ab_prev, ab}) inside
          4'b0010, 4'b0100, 4'b1011, 4'b1101: d = 1;
          4'b0001, 4'b0111, 4'b1000, 4'b1110: d = -1;
          default: d = 0;
        endcase
        ab_prev = ab;
        if (d != 0) begin
          acc      = step_sum + d;
          modified = enc_held && !enc_long_done;
          if (acc >= int'(cfg_steps)) begin
            acc = 0;
            seq_no++;
            if (modified) begin
              add_triple(reb_pkg::KEY_RIGHT, seq_no);
              enc_turned = 1'b1;
            end else begin
              add_triple(reb_pkg::KEY_DOWN, seq_no);
            end
          end else if (acc <= -int'(cfg_steps)) begin
            acc = 0;
            seq_no++;
            if (modified) begin
              add_triple(reb_pkg::KEY_LEFT, seq_no);
              enc_turned = 1'b1;
            end else begin
              add_triple(reb_pkg::KEY_UP, seq_no);
            end
          end
          step_sum = acc;
        end
      end

      // encoder push button
      settle(enc_raw_q, enc_cnt, enc_p, ok);
      if (ok) begin
        if (enc_held == enc_raw_q) begin
          held_for = now - enc_t0;
          if (enc_held && !enc_long_done && held_for >= cfg_long_ticks) begin
            enc_long_done = 1'b1;
            seq_no++;
            add_event(reb_pkg::KEY_OK, reb_pkg::KIND_PRESS, seq_no);
            add_event(reb_pkg::KEY_OK, reb_pkg::KIND_LONG, seq_no);
          end
        end else begin
          enc_held = enc_raw_q;
          if (enc_held) begin
            enc_t0        = now;
            enc_turned    = 1'b0;
            enc_long_done = 1'b0;
          end else begin
            if (enc_long_done) begin
              seq_no++;
              add_event(reb_pkg::KEY_OK, reb_pkg::KIND_RELEASE, seq_no);
            end else if (!enc_turned) begin
              seq_no++;
              add_triple(reb_pkg::KEY_OK, seq_no);
            end
            enc_turned = 1'b0;
          end
        end
      end

      // side key with long press and repeat
      settle(key_raw_q, key_cnt, key_p, ok);
      if (ok) begin
        if (key_held == key_raw_q) begin
          held_for  = now - key_t0;
          since_rep = now - key_rep_t;
          if (key_held) begin
            if (!key_long_done && held_for >= cfg_long_ticks) begin
              key_long_done = 1'b1;
              key_rep_t     = now;
              seq_no++;
              add_event(reb_pkg::KEY_BACK, reb_pkg::KIND_PRESS, seq_no);
              add_event(reb_pkg::KEY_BACK, reb_pkg::KIND_LONG, seq_no);
            end else if (key_long_done && since_rep >= cfg_repeat_ticks) begin
              key_rep_t = now;
              add_event(reb_pkg::KEY_BACK, reb_pkg::KIND_REPEAT, seq_no);
            end
          end
        end else begin
          key_held = key_raw_q;
          if (key_held) begin
            key_t0        = now;
            key_long_done = 1'b0;
          end else if (!key_long_done) begin
            seq_no++;
            add_triple(reb_pkg::KEY_BACK, seq_no);
          end else begin
            add_event(reb_pkg::KEY_BACK, reb_pkg::KIND_RELEASE, seq_no);
          end
        end
      end

      // mark the final event of the poll and queue them
      for (int i = 0; i < poll_events.size(); i++) begin
        ev = poll_events[i];
        ev.last_of_poll = (i == poll_events.size() - 1);
        pending_events.push_back(ev);
      end
    end
  endtask

  // --------------------------------------------------------------- checker --

  always @(posedge clk) begin : event_check
    reb_pkg::out_item_t want;
    if (rst_n === 1'b1 && out_valid === 1'b1 && out_ready === 1'b1) begin
      if (pending_events.size() == 0) begin
        flag_error("event with none pending", 64'(out_data), 64'd0);
      end else begin
        want = pending_events.pop_front();
        if (out_data.event_key !== want.event_key)
          flag_error("event_key", 64'(out_data.event_key), 64'(want.event_key));
        if (out_data.event_kind !== want.event_kind)
          flag_error("event_kind", 64'(out_data.event_kind), 64'(want.event_kind));
        if (out_data.event_seq !== want.event_seq)
          flag_error("event_seq", 64'(out_data.event_seq), 64'(want.event_seq));
        if (out_data.last_of_poll !== want.last_of_poll)
          flag_error("last_of_poll", 64'(out_data.last_of_poll),
                     64'(want.last_of_poll));
      end
    end
  end

  // receiver pacing, with a long hold-off on request
  initial begin : rx_pacing
    pace_t mode;
    int    mode_left;
    int    held_left;
    out_ready = 1'b0;
    mode      = PACE_FLOW;
    mode_left = 0;
    held_left = 0;
    forever begin
      @(negedge clk);
      if (hold_request) begin
        hold_request = 1'b0;
        held_left    = HOLD_CYCLES;
      end
      if (held_left > 0) begin
        held_left--;
        out_ready <= 1'b0;
      end else begin
        if (mode_left == 0) begin
          mode = pace_t'($urandom_range(0, 2));
          case (mode)
            PACE_FLOW:  mode_left = $urandom_range(10, 60);
            PACE_STALL: mode_left = $urandom_range(1, 8);
            default:    mode_left = $urandom_range(5, 30);
          endcase
        end
        mode_left--;
        case (mode)
          PACE_FLOW:  out_ready <= 1'b1;
          PACE_STALL: out_ready <= 1'b0;
          default:    out_ready <= ($urandom_range(0, 1) != 0);
        endcase
      end
    end
  end

  // ---------------------------------------------------------------- driver --

  function automatic reb_pkg::in_item_t mk_poll(input logic [1:0] ab, input bit enc_lvl,
                                                input bit key_lvl, input logic [31:0] t);
    reb_pkg::in_item_t it;
    it.phase_a          = ab[1];
    it.phase_b          = ab[0];
    it.enc_button_level = enc_lvl;
    it.side_key_level   = key_lvl;
    it.now_tick         = t;
    return it;
  endfunction

  // quadrature position to AB levels, clockwise order
  function automatic logic [1:0] gray_ab(input int pos);
    case (pos & 3)
      0:       return 2'b00;
      1:       return 2'b10;
      2:       return 2'b11;
      default: return 2'b01;
    endcase
  endfunction

  // one poll request; called and returns at a falling edge
  task automatic send_poll(input reb_pkg::in_item_t it);
    if (gaps_enabled && burst_left == 0) begin
      burst_left = ($urandom_range(0, 5) == 0) ? $urandom_range(20, 40)
                                               : $urandom_range(1, 10);
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(negedge clk);
    end
    if (burst_left > 0) burst_left--;
    in_valid <= 1'b1;
    in_data  <= it;
    do @(posedge clk); while (in_ready !== 1'b1);
    decode_poll(it);
    @(negedge clk);
  endtask

  // stop sending and wait until every expected event has come
  task automatic wait_idle();
    in_valid <= 1'b0;
    while (pending_events.size() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic write_config(input logic [31:0] long_t, input logic [31:0] rep_t,
                              input logic [3:0] deb, input logic [3:0] steps);
    cfg_we    <= 1'b1;
    cfg_index <= reb_pkg::CFG_LONG_TICKS;
    cfg_wdata <= long_t;
    @(negedge clk);
    cfg_index <= reb_pkg::CFG_REPEAT_TICKS;
    cfg_wdata <= rep_t;
    @(negedge clk);
    cfg_index <= reb_pkg::CFG_DEBOUNCE;
    cfg_wdata <= {28'd0, deb};
    @(negedge clk);
    cfg_index <= reb_pkg::CFG_STEPS;
    cfg_wdata <= {28'd0, steps};
    @(negedge clk);
    cfg_we <= 1'b0;
    cfg_long_ticks   = long_t;
    cfg_repeat_ticks = rep_t;
    cfg_debounce     = deb;
    cfg_steps        = steps;
    @(negedge clk);
  endtask

  // random gesture stream: rotation runs, held buttons, bounces, tick jumps
  task automatic make_random_poll(output reb_pkg::in_item_t it);
    logic [31:0] span;
    bit          enc_lvl, key_lvl;
    case ($urandom_range(0, 9)) inside
      0: begin
        gen_dir = -gen_dir;
        gen_pos = (gen_pos + gen_dir) & 3;
      end
      1:    gen_pos = (gen_pos + 2) & 3;   // illegal jump
      2, 3: ;                              // no movement
      default: gen_pos = (gen_pos + gen_dir) & 3;
    endcase

    if (gen_enc_left == 0) begin
      gen_enc_lvl  = ~gen_enc_lvl;
      gen_enc_left = $urandom_range(1, 2 * cfg_debounce + 6);
    end
    gen_enc_left--;
    if (gen_key_left == 0) begin
      gen_key_lvl  = ~gen_key_lvl;
      gen_key_left = $urandom_range(1, 2 * cfg_debounce + 6);
    end
    gen_key_left--;
    // occasional one-poll contact bounce
    enc_lvl = gen_enc_lvl ^ ($urandom_range(0, 15) == 0);
    key_lvl = gen_key_lvl ^ ($urandom_range(0, 15) == 0);

    span = (cfg_long_ticks > 32'd1000) ? 32'd1000 : cfg_long_ticks;
    case ($urandom_range(0, 19)) inside
      0:          gen_tick = $urandom;
      1, 2, 3, 4: gen_tick = gen_tick + $urandom_range(0, span + span / 2 + 2);
      default:    gen_tick = gen_tick + $urandom_range(1, 8);
    endcase
    it = mk_poll(gray_ab(gen_pos), enc_lvl, key_lvl, gen_tick);
  endtask

  // ----------------------------------------------------------------- tests --

  // priming poll, detents both ways, illegal jump, tick extremes
  task automatic test_rotation();
    send_poll(mk_poll(2'b00, RELEASED, RELEASED, 32'h0000_0000));
    send_poll(mk_poll(2'b10, RELEASED, RELEASED, 32'd1));
    send_poll(mk_poll(2'b11, RELEASED, RELEASED, 32'd2));
    send_poll(mk_poll(2'b01, RELEASED, RELEASED, 32'd3));
    send_poll(mk_poll(2'b00, RELEASED, RELEASED, 32'd4));
    send_poll(mk_poll(2'b11, RELEASED, RELEASED, 32'd5));
    send_poll(mk_poll(2'b10, RELEASED, RELEASED, 32'd6));
    send_poll(mk_poll(2'b00, RELEASED, RELEASED, 32'hFFFF_FFFF));
  endtask

  // turn while held, ok short, ok long across the tick wrap
  task automatic test_ok_button();
    wait_idle();
    write_config(32'd500, 32'd200, 4'd1, 4'd2);
    send_poll(mk_poll(2'b00, PRESSED, RELEASED, 32'hFFFF_FF00));
    send_poll(mk_poll(2'b10, PRESSED, RELEASED, 32'hFFFF_FF01));
    send_poll(mk_poll(2'b11, PRESSED, RELEASED, 32'hFFFF_FF02));
    send_poll(mk_poll(2'b11, RELEASED, RELEASED, 32'hFFFF_FF03));
    send_poll(mk_poll(2'b11, PRESSED, RELEASED, 32'd10));
    send_poll(mk_poll(2'b11, RELEASED, RELEASED, 32'd20));
    send_poll(mk_poll(2'b11, PRESSED, RELEASED, 32'hFFFF_FF00));
    send_poll(mk_poll(2'b11, PRESSED, RELEASED, 32'h0000_00F4));
    send_poll(mk_poll(2'b01, PRESSED, RELEASED, 32'h0000_0100));
    send_poll(mk_poll(2'b00, PRESSED, RELEASED, 32'h0000_0101));
    send_poll(mk_poll(2'b00, RELEASED, RELEASED, 32'h0000_0102));
  endtask

  // back long, repeat, release with current sequence, then back short
  task automatic test_back_key();
    send_poll(mk_poll(2'b00, RELEASED, PRESSED, 32'd1000));
    send_poll(mk_poll(2'b00, RELEASED, PRESSED, 32'd1499));
    send_poll(mk_poll(2'b00, RELEASED, PRESSED, 32'd1500));
    send_poll(mk_poll(2'b00, RELEASED, PRESSED, 32'd1700));
    send_poll(mk_poll(2'b00, RELEASED, RELEASED, 32'd1900));
    send_poll(mk_poll(2'b00, RELEASED, PRESSED, 32'd2000));
    send_poll(mk_poll(2'b00, RELEASED, RELEASED, 32'd2001));
  endtask

  // zero settings: instant debounce, per-step detents, instant long and repeat
  task automatic test_zero_settings();
    wait_idle();
    write_config(32'd0, 32'd0, 4'd0, 4'd0);
    send_poll(mk_poll(2'b10, PRESSED, PRESSED, 32'd5000));
    send_poll(mk_poll(2'b11, PRESSED, PRESSED, 32'd5000));
    send_poll(mk_poll(2'b11, PRESSED, PRESSED, 32'd5001));
    send_poll(mk_poll(2'b01, RELEASED, RELEASED, 32'd5002));
  endtask

  // receiver held off while rotation requests keep coming, then full drain
  task automatic test_backpressure();
    wait_idle();
    write_config(32'd50, 32'd10, 4'd1, 4'd1);
    gaps_enabled = 1'b0;
    hold_request = 1'b1;
    for (int i = 0; i < 24; i++) begin
      gen_pos  = (gen_pos + 1) & 3;
      gen_tick = gen_tick + 32'd1;
      send_poll(mk_poll(gray_ab(gen_pos), RELEASED, RELEASED, gen_tick));
    end
    wait_idle();
    gaps_enabled = 1'b1;
  endtask

  // random gesture streams under reset, extreme and random settings
  task automatic test_random_polls();
    reb_pkg::in_item_t it;
    for (int ph = 0; ph < 6; ph++) begin
      wait_idle();
      case (ph)
        0: write_config(reb_pkg::LONG_TICKS_RST, reb_pkg::REPEAT_TICKS_RST,
                        reb_pkg::DEBOUNCE_RST, reb_pkg::STEPS_RST);
        1: write_config(32'hFFFF_FFFF, 32'hFFFF_FFFF, 4'd15, 4'd8);
        2: write_config(32'd1, 32'd1, 4'd1, 4'd1);
        default: write_config($urandom_range(10, 400), $urandom_range(0, 150),
                              4'($urandom_range(0, 4)), 4'($urandom_range(0, 4)));
      endcase
      for (int i = 0; i < 43; i++) begin
        make_random_poll(it);
        send_poll(it);
        if ($urandom_range(0, 39) == 0) wait_idle();
      end
    end
  endtask

  // ------------------------------------------------------------------ run --

  initial begin : run
    rst_n     = 1'b0;
    cfg_we    = 1'b0;
    cfg_index = '0;
    cfg_wdata = '0;
    in_valid  = 1'b0;
    in_data   = '0;

    cfg_long_ticks   = reb_pkg::LONG_TICKS_RST;
    cfg_repeat_ticks = reb_pkg::REPEAT_TICKS_RST;
    cfg_debounce     = reb_pkg::DEBOUNCE_RST;
    cfg_steps        = reb_pkg::STEPS_RST;
    primed_q      = 1'b0;
    ab_prev       = 2'b00;
    step_sum      = 0;
    seq_no        = '0;
    enc_raw_q     = 1'b0;
    enc_held      = 1'b0;
    enc_long_done = 1'b0;
    enc_turned    = 1'b0;
    enc_cnt       = reb_pkg::DEBOUNCE_RST;
    enc_t0        = '0;
    key_raw_q     = 1'b0;
    key_held      = 1'b0;
    key_long_done = 1'b0;
    key_cnt       = reb_pkg::DEBOUNCE_RST;
    key_t0        = '0;
    key_rep_t     = '0;

    mismatch_count = 0;
    burst_left     = 0;
    gaps_enabled   = 1'b1;
    hold_request   = 1'b0;
    gen_pos        = 0;
    gen_dir        = 1;
    gen_enc_left   = 0;
    gen_key_left   = 0;
    gen_enc_lvl    = PRESSED;
    gen_key_lvl    = PRESSED;
    gen_tick       = 32'd3000;

    repeat (12) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    test_rotation();
    test_ok_button();
    test_back_key();
    test_zero_settings();
    test_backpressure();
    test_random_polls();
    wait_idle();

    if (mismatch_count == 0)
      $display("[ OK ] regression clean");
    else
      $display("[FAIL] regression broken");
    $finish;
  end

endmodule

// ===== files.f =====
+incdir+hw/rtl
hw/rtl/reb_pkg.sv
hw/rtl/reb_front.sv
hw/rtl/reb_queue.sv
hw/rtl/reb_back.sv
hw/rtl/rotary_encoder_button_events_top.sv
sim/rotary_encoder_button_events_top_tb.sv
